[hdl/vmt_pkg.sv]
// vmt_pkg: shared types and constants for the 4x4 matrix vector transform
// holds the beat type that travels along the cell chain and the item codes
// no dependencies
package vmt_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned DIM    = 4;
  localparam int unsigned IDX_W  = 4;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_XFORM = 1'b1;

  typedef struct packed {
    logic                           valid;
    logic                           func;
    logic [IDX_W-1:0]               index;
    logic [DATA_W-1:0]              value;
    logic [DIM-1:0][DATA_W-1:0]     vec;
    logic [DIM-1:0][SUM_W-1:0]      sums;
  } beat_t;

endpackage

[hdl/vector_matrix4_transform.sv]
// vector_matrix4_transform: row vector times stored 4x4 matrix, signed fixed point
// one beat per cycle sustained while out_stall does not hold the output register
// the chain of four row cells, each a multiply and an add stage, feeds vmt_sat
// rst (synchronous) clears the matrix to zero and empties the pipeline
// loads travel down the chain in order, so each transform sees all earlier loads
// depends on vmt_pkg, vmt_cell, vmt_sat
module vector_matrix4_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [3:0]  entry_index,
  input  logic signed [31:0] entry_value,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [31:0] in_w,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  output logic        overflow
);

  // links between cells: link[0] is the incoming beat, link[DIM] feeds saturation
  vmt_pkg::beat_t link [vmt_pkg::DIM+1];
  logic           adv;
  logic [vmt_pkg::DIM-1:0][vmt_pkg::DATA_W-1:0] res;

  // the whole chain moves together whenever the output register can take a beat
  assign in_stall = !adv;

  always_comb begin
    link[0].valid  = in_valid;
    link[0].func   = func;
    link[0].index  = entry_index;
    link[0].value  = entry_value;
    link[0].vec[0] = in_x;
    link[0].vec[1] = in_y;
    link[0].vec[2] = in_z;
    link[0].vec[3] = in_w;
    // column sums start at zero and pick up one product per row cell
    link[0].sums   = '0;
  end

  for (genvar r = 0; r < vmt_pkg::DIM; r++) begin : g_row
    vmt_cell #(
      .ROW (2'(r))
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .beat_in  (link[r]),
      .beat_out (link[r+1])
    );
  end

  // arithmetic shift by the fraction bits, saturate to 32 bits, register the beat
  vmt_sat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sat (
    .clk       (clk),
    .rst       (rst),
    .beat_in   (link[vmt_pkg::DIM]),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .res       (res),
    .overflow  (overflow)
  );

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_w = res[3];

endmodule

[hdl/vmt_cell.sv]
// vmt_cell: one matrix row of the transform chain, two register stages
// multiplies its vector component by its row and adds into the column sums
// depends on vmt_pkg
module vmt_cell #(
  parameter logic [1:0] ROW = 2'd0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  vmt_pkg::beat_t beat_in,
  output vmt_pkg::beat_t beat_out
);

  logic [vmt_pkg::DATA_W-1:0] mat [vmt_pkg::DIM];
  vmt_pkg::beat_t             s1;
  logic signed [vmt_pkg::PROD_W-1:0] prod      [vmt_pkg::DIM];
  logic signed [vmt_pkg::PROD_W-1:0] prod_next [vmt_pkg::DIM];
  logic load_hit;

  assign load_hit = beat_in.valid && (beat_in.func == vmt_pkg::FUNC_LOAD)
                    && (beat_in.index[3:2] == ROW);

  // row entries, cleared at reset, written when a load beat reaches this row
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < vmt_pkg::DIM; c++) begin
        mat[c] <= '0;
      end
    end else if (adv && load_hit) begin
      mat[beat_in.index[1:0]] <= beat_in.value;
    end
  end

  always_comb begin
    for (int c = 0; c < vmt_pkg::DIM; c++) begin
      prod_next[c] = $signed(beat_in.vec[ROW]) * $signed(mat[c]);
    end
  end

  // stage one: products
  always_ff @(posedge clk) begin
    if (adv) begin
      s1.func  <= beat_in.func;
      s1.index <= beat_in.index;
      s1.value <= beat_in.value;
      s1.vec   <= beat_in.vec;
      s1.sums  <= beat_in.sums;
      for (int c = 0; c < vmt_pkg::DIM; c++) begin
        prod[c] <= prod_next[c];
      end
    end
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (adv) begin
      s1.valid <= beat_in.valid;
    end
  end

  // stage two: accumulate into the running column sums
  always_ff @(posedge clk) begin
    if (adv) begin
      beat_out.func  <= s1.func;
      beat_out.index <= s1.index;
      beat_out.value <= s1.value;
      beat_out.vec   <= s1.vec;
      for (int c = 0; c < vmt_pkg::DIM; c++) begin
        beat_out.sums[c] <= s1.sums[c]
          + {{(vmt_pkg::SUM_W - vmt_pkg::PROD_W){prod[c][vmt_pkg::PROD_W-1]}}, prod[c]};
      end
    end
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else if (adv) begin
      beat_out.valid <= s1.valid;
    end
  end

endmodule

[hdl/vmt_sat.sv]
// vmt_sat: shift, saturation and output register at the end of the chain
// drops load beats, makes the chain advance signal from the output stall
// depends on vmt_pkg
module vmt_sat #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  vmt_pkg::beat_t             beat_in,
  input  logic                       out_stall,
  output logic                       adv,
  output logic                       out_valid,
  output logic [vmt_pkg::DIM-1:0][vmt_pkg::DATA_W-1:0] res,
  output logic                       overflow
);

  localparam int unsigned SW = vmt_pkg::SUM_W;
  localparam int unsigned DW = vmt_pkg::DATA_W;

  logic [vmt_pkg::DIM-1:0][DW-1:0] res_next;
  logic [vmt_pkg::DIM-1:0]         sat;
  logic signed [SW-1:0]            shifted [vmt_pkg::DIM];

  assign adv = !out_valid || !out_stall;

  always_comb begin
    for (int c = 0; c < vmt_pkg::DIM; c++) begin
      shifted[c] = $signed(beat_in.sums[c]) >>> FRAC_BITS;
      sat[c] = !((&shifted[c][SW-1:DW-1]) || !(|shifted[c][SW-1:DW-1]));
      if (sat[c]) begin
        res_next[c] = shifted[c][SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
        res_next[c] = shifted[c][DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= beat_in.valid && (beat_in.func == vmt_pkg::FUNC_XFORM);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res      <= res_next;
      overflow <= |sat;
    end
  end

endmodule
